// ----- sv/snapped_vertex_weld_hash_defines.svh -----
// Assertion helpers for the weld hash datapath.
`ifndef SNAPPED_VERTEX_WELD_HASH_DEFINES_SVH
`define SNAPPED_VERTEX_WELD_HASH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVWH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svwh: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SVWH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svwh: next-cycle check failed");

`endif

// ----- sv/svwh_pkg.sv -----
package svwh_pkg;

    localparam int COORD_W  = 25;
    localparam int SNAP_W   = 22;
    localparam int SIZE_W   = 23;
    localparam int IDX_W    = 12;
    localparam int DIV_NW   = 22;
    localparam int AXES     = 3;
    localparam int SNAP_MAX = 2097151;
    localparam int SNAP_MIN = -2097152;

    localparam logic [2:0] REG_GMIN_X  = 3'd0;
    localparam logic [2:0] REG_GMIN_Y  = 3'd1;
    localparam logic [2:0] REG_GMIN_Z  = 3'd2;
    localparam logic [2:0] REG_BSIZE_X = 3'd3;
    localparam logic [2:0] REG_BSIZE_Y = 3'd4;
    localparam logic [2:0] REG_BSIZE_Z = 3'd5;

    typedef struct packed {
        logic [AXES-1:0][SNAP_W-1:0] gmin;
        logic [AXES-1:0][SIZE_W-1:0] bsize;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_MATCH,
        KIND_NEW,
        KIND_FULL,
        KIND_ZERO
    } out_kind_t;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       bin_load;
        logic [1:0] axis;
        logic       walk_init;
        logic       walk_next;
        logic       head_rd;
        logic       home_rd;
        logic       p_from_head;
        logic       p_from_link;
        logic       ent_rd;
        logic       insert;
        logic       clr_step;
        logic       out_load;
        out_kind_t  out_kind;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic p_valid;
        logic match;
        logic link_stop;
        logic walk_last;
        logic full;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/svwh_ram.sv -----
module svwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/svwh_div.sv -----
// Restoring divider, one quotient bit per cycle.
module svwh_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [svwh_pkg::DIV_NW-1:0]      numer,
    input  logic [svwh_pkg::SIZE_W-1:0]      denom,
    output logic                             done,
    output logic [svwh_pkg::DIV_NW-1:0]      quot,
    output logic [svwh_pkg::SIZE_W-1:0]      rem
);

    localparam int NW = svwh_pkg::DIV_NW;
    localparam int DW = svwh_pkg::SIZE_W;
    localparam int CNTW = $clog2(NW);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;
    logic            ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        ge        = trial >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = CNTW'(NW - 1);
            busy_next = 1'b1;
            quo_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- sv/svwh_datapath.sv -----
`include "snapped_vertex_weld_hash_defines.svh"

module svwh_datapath #(
    parameter int BINS_PER_AXIS   = 64,
    parameter int MAX_VERTS       = 4096,
    parameter int SNAP_STEPS      = 32,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  svwh_pkg::cfg_t                      cfg,
    input  logic [svwh_pkg::COORD_W-1:0]        in_x,
    input  logic [svwh_pkg::COORD_W-1:0]        in_y,
    input  logic [svwh_pkg::COORD_W-1:0]        in_z,
    input  svwh_pkg::cmd_t                      cmd,
    output svwh_pkg::sts_t                      sts,
    input  logic                                m_tready,
    output logic                                out_valid,
    output logic [svwh_pkg::IDX_W-1:0]          out_index,
    output logic [svwh_pkg::SNAP_W-1:0]         out_x,
    output logic [svwh_pkg::SNAP_W-1:0]         out_y,
    output logic [svwh_pkg::SNAP_W-1:0]         out_z,
    output logic                                out_new,
    output logic                                out_full
);

    localparam int SW   = svwh_pkg::SNAP_W;
    localparam int CWID = svwh_pkg::COORD_W;
    localparam int NW   = svwh_pkg::DIV_NW;
    localparam int ZW   = svwh_pkg::SIZE_W;
    localparam int BW   = $clog2(BINS_PER_AXIS);
    localparam int NUM_BINS = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int HAW  = $clog2(NUM_BINS);
    localparam int CW   = $clog2(MAX_VERTS + 1);
    localparam int EW   = $clog2(MAX_VERTS);
    localparam int MW   = $clog2(SNAP_STEPS + 1);
    localparam int PW   = CWID + MW + 1;
    localparam int HALF = 1 << (COORD_FRAC_BITS - 1);
    localparam int ENT_W = 3 * SW + CW;

    function automatic logic [SW-1:0] snap_of(input logic [CWID-1:0] c);
        logic signed [PW-1:0] n;
        logic signed [PW-1:0] q;
        n = PW'($signed(c)) * PW'(SNAP_STEPS) + PW'(HALF);
        q = n >>> COORD_FRAC_BITS;
        if (q > PW'(svwh_pkg::SNAP_MAX))
        begin
            return SW'(svwh_pkg::SNAP_MAX);
        end
        else if (q < PW'(svwh_pkg::SNAP_MIN))
        begin
            return SW'(svwh_pkg::SNAP_MIN);
        end
        return q[SW-1:0];
    endfunction

    function automatic logic [BW-1:0] clamp_bin(input logic [NW:0] v);
        if (v > (NW + 1)'(BINS_PER_AXIS - 1))
        begin
            return BW'(BINS_PER_AXIS - 1);
        end
        return v[BW-1:0];
    endfunction

    function automatic logic near1(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic signed [SW:0] d;
        d = $signed({a[SW-1], a}) - $signed({b[SW-1], b});
        return (d >= -(SW + 1)'(1)) && (d <= (SW + 1)'(1));
    endfunction

    // Per-axis state of the item at work.
    logic [SW-1:0] snap_reg [svwh_pkg::AXES];
    logic [BW-1:0] lo_reg   [svwh_pkg::AXES];
    logic [BW-1:0] hi_reg   [svwh_pkg::AXES];
    logic [BW-1:0] home_reg [svwh_pkg::AXES];
    logic [BW-1:0] bx_reg, by_reg, bz_reg;
    logic [CW-1:0] p_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [HAW-1:0] clr_reg, clr_next;

    logic          out_valid_reg, out_valid_next;
    logic [svwh_pkg::IDX_W-1:0] idx_reg;
    logic [SW-1:0] ox_reg, oy_reg, oz_reg;
    logic          new_reg, full_reg;

    logic [SW:0]   nv   [svwh_pkg::AXES];
    logic [ZW-1:0] dsel;
    logic [NW-1:0] div_numer;
    logic          div_done;
    logic [NW-1:0] div_quot;
    logic [ZW-1:0] div_rem;
    logic [NW:0]   qv, qh, ql;
    logic          sel_neg, sel_zero;

    logic [HAW-1:0] walk_addr, home_addr;
    logic           head_we, head_re;
    logic [HAW-1:0] head_waddr, head_raddr;
    logic [CW-1:0]  head_wdata, head_rdata;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    logic [SW-1:0]  ent_x, ent_y, ent_z;
    logic [CW-1:0]  ent_link;
    logic           p_valid, count_full, clr_last;
    logic [CW-1:0]  e_idx;
    logic [31:0]    idx_wide;

    always_comb
    begin
        for (int a = 0; a < svwh_pkg::AXES; a++)
        begin
            nv[a] = {snap_reg[a][SW-1], snap_reg[a]} - {cfg.gmin[a][SW-1], cfg.gmin[a]};
        end
        dsel      = (cfg.bsize[cmd.axis] == '0) ? ZW'(1) : cfg.bsize[cmd.axis];
        div_numer = nv[cmd.axis][NW-1:0];
        sel_neg   = nv[cmd.axis][SW];
        sel_zero  = nv[cmd.axis] == '0;
        // Neighbor bins from one quotient: n+1 crosses up when the remainder
        // sits at the top, n-1 crosses down when it is zero.
        qv = {1'b0, div_quot};
        qh = qv + (NW + 1)'(div_rem == dsel - 1'b1);
        ql = sel_zero ? '0 : qv - (NW + 1)'(div_rem == '0);
    end

    svwh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (div_numer),
        .denom (dsel),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign walk_addr = HAW'(HAW'(HAW'(bx_reg) * HAW'(BINS_PER_AXIS) + HAW'(by_reg))
                       * HAW'(BINS_PER_AXIS) + HAW'(bz_reg));
    assign home_addr = HAW'(HAW'(HAW'(home_reg[0]) * HAW'(BINS_PER_AXIS) + HAW'(home_reg[1]))
                       * HAW'(BINS_PER_AXIS) + HAW'(home_reg[2]));

    assign head_we    = cmd.clr_step || cmd.insert;
    assign head_waddr = cmd.clr_step ? clr_reg : home_addr;
    assign head_wdata = cmd.clr_step ? '0 : count_reg + 1'b1;
    assign head_re    = cmd.head_rd || cmd.home_rd;
    assign head_raddr = cmd.home_rd ? home_addr : walk_addr;

    svwh_ram #(.WIDTH(CW), .DEPTH(NUM_BINS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    assign ent_wdata = {head_rdata, snap_reg[2], snap_reg[1], snap_reg[0]};

    svwh_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTS)) u_ent_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (count_reg[EW-1:0]),
        .wdata (ent_wdata),
        .re    (cmd.ent_rd),
        .raddr (EW'(p_reg - 1'b1)),
        .rdata (ent_rdata)
    );

    assign ent_x    = ent_rdata[SW-1:0];
    assign ent_y    = ent_rdata[2*SW-1:SW];
    assign ent_z    = ent_rdata[3*SW-1:2*SW];
    assign ent_link = ent_rdata[ENT_W-1:3*SW];

    assign p_valid    = (p_reg != '0) && (p_reg <= count_reg);
    assign count_full = count_reg >= CW'(MAX_VERTS);
    assign clr_last   = clr_reg == HAW'(NUM_BINS - 1);

    always_comb
    begin
        sts.div_done  = div_done;
        sts.p_valid   = p_valid;
        sts.match     = near1(ent_x, snap_reg[0]) && near1(ent_y, snap_reg[1])
                        && near1(ent_z, snap_reg[2]);
        sts.link_stop = ent_link >= p_reg;
        sts.walk_last = (bx_reg == hi_reg[0]) && (by_reg == hi_reg[1])
                        && (bz_reg == hi_reg[2]);
        sts.full      = count_full;
        sts.clr_last  = clr_last;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        count_next = count_reg;
        clr_next   = clr_reg;
        if (cmd.clr_step)
        begin
            count_next = '0;
            clr_next   = clr_last ? '0 : clr_reg + 1'b1;
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        e_idx = (cmd.out_kind == svwh_pkg::KIND_MATCH) ? p_reg - 1'b1 : count_reg - 1'b1;
        idx_wide = 32'(e_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            snap_reg[0] <= snap_of(in_x);
            snap_reg[1] <= snap_of(in_y);
            snap_reg[2] <= snap_of(in_z);
        end
        if (cmd.bin_load)
        begin
            lo_reg[cmd.axis]   <= sel_neg ? '0 : clamp_bin(ql);
            hi_reg[cmd.axis]   <= sel_neg ? '0 : clamp_bin(qh);
            home_reg[cmd.axis] <= sel_neg ? '0 : clamp_bin(qv);
        end
        if (cmd.walk_init)
        begin
            bx_reg <= lo_reg[0];
            by_reg <= lo_reg[1];
            bz_reg <= lo_reg[2];
        end
        else if (cmd.walk_next)
        begin
            if (bz_reg != hi_reg[2])
            begin
                bz_reg <= bz_reg + 1'b1;
            end
            else
            begin
                bz_reg <= lo_reg[2];
                if (by_reg != hi_reg[1])
                begin
                    by_reg <= by_reg + 1'b1;
                end
                else
                begin
                    by_reg <= lo_reg[1];
                    bx_reg <= bx_reg + 1'b1;
                end
            end
        end
        if (cmd.p_from_head)
        begin
            p_reg <= head_rdata;
        end
        else if (cmd.p_from_link)
        begin
            p_reg <= ent_link;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                svwh_pkg::KIND_MATCH:
                begin
                    idx_reg  <= idx_wide[svwh_pkg::IDX_W-1:0];
                    ox_reg   <= ent_x;
                    oy_reg   <= ent_y;
                    oz_reg   <= ent_z;
                    new_reg  <= 1'b0;
                    full_reg <= 1'b0;
                end
                svwh_pkg::KIND_NEW:
                begin
                    idx_reg  <= idx_wide[svwh_pkg::IDX_W-1:0];
                    ox_reg   <= snap_reg[0];
                    oy_reg   <= snap_reg[1];
                    oz_reg   <= snap_reg[2];
                    new_reg  <= 1'b1;
                    full_reg <= 1'b0;
                end
                svwh_pkg::KIND_FULL:
                begin
                    idx_reg  <= '0;
                    ox_reg   <= snap_reg[0];
                    oy_reg   <= snap_reg[1];
                    oz_reg   <= snap_reg[2];
                    new_reg  <= 1'b0;
                    full_reg <= 1'b1;
                end
                default:
                begin
                    idx_reg  <= '0;
                    ox_reg   <= '0;
                    oy_reg   <= '0;
                    oz_reg   <= '0;
                    new_reg  <= 1'b0;
                    full_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = idx_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign out_new   = new_reg;
    assign out_full  = full_reg;

    `SVWH_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_VERTS))
    `SVWH_ASSERT_NOW(a_insert_room, cmd.insert, !count_full)
    `SVWH_ASSERT_NOW(a_read_guard, cmd.ent_rd, p_valid)
    `SVWH_ASSERT_NEXT(a_clear_count, cmd.clr_step && clr_last, count_reg == '0)

endmodule

// ----- sv/svwh_ctrl.sv -----
module svwh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_clear,
    output logic           in_ready,
    input  svwh_pkg::sts_t sts,
    output svwh_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WALK_INIT,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_ENT_CHK,
        S_ENT_WAIT,
        S_NEXT,
        S_INS,
        S_HOME_WAIT,
        S_CLR,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          axis_reg, axis_next;
    svwh_pkg::out_kind_t kind_reg, kind_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        kind_next  = kind_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.axis     = axis_reg;
        cmd.out_kind = kind_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_clear)
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        cmd.load_in = 1'b1;
                        axis_next   = 2'd0;
                        state_next  = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.bin_load = 1'b1;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_WALK_INIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                cmd.p_from_head = 1'b1;
                state_next      = S_ENT_CHK;
            end
            S_ENT_CHK:
            begin
                if (sts.p_valid)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENT_WAIT;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ENT_WAIT:
            begin
                if (sts.match)
                begin
                    kind_next  = svwh_pkg::KIND_MATCH;
                    state_next = S_RESULT;
                end
                else if (sts.link_stop)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.p_from_link = 1'b1;
                    state_next      = S_ENT_CHK;
                end
            end
            S_NEXT:
            begin
                if (sts.walk_last)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                    state_next    = S_HEAD_RD;
                end
            end
            S_INS:
            begin
                if (sts.full)
                begin
                    kind_next  = svwh_pkg::KIND_FULL;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.home_rd = 1'b1;
                    state_next  = S_HOME_WAIT;
                end
            end
            S_HOME_WAIT:
            begin
                cmd.insert = 1'b1;
                kind_next  = svwh_pkg::KIND_NEW;
                state_next = S_RESULT;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    kind_next  = svwh_pkg::KIND_ZERO;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            axis_reg  <= 2'd0;
            kind_reg  <= svwh_pkg::KIND_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ----- sv/snapped_vertex_weld_hash.sv -----
// Weld: bin division for each of the 3 axes in turn, then a walk of up to 27 bins that checks
// each chain entry in them, plus accept, walk setup, insert and result.
// Clear: every hash bin (BINS_PER_AXIS^3, 262144 by default) is set empty, then the result is given.
// One transaction is worked on at a time; the three axes share one divider. After rst_n
// is released the bin memory, 262144 bins at the default size, is swept with s_tready
// low; configuration writes are taken throughout.
module snapped_vertex_weld_hash #(
    parameter int BINS_PER_AXIS   = 64,
    parameter int MAX_VERTS       = 4096,
    parameter int SNAP_STEPS      = 32,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // coord_x[24:0], coord_y[49:25], coord_z[74:50], zero pad
    input  logic [0:0]  s_tuser,  // operation
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // vertex_index[11:0], snap_x[33:12], snap_y[55:34],
                                  // snap_z[77:56], zero pad
    output logic [1:0]  m_tuser,  // is_new, table_full
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = svwh_pkg::SNAP_W;
    localparam int ZW = svwh_pkg::SIZE_W;
    localparam int CWID = svwh_pkg::COORD_W;

    // Configuration registers. Grid origins are kept as raw 22-bit two's complement,
    // bin sizes as 23-bit magnitudes; a zero size is read as one by the datapath.
    svwh_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    svwh_pkg::cmd_t cmd;
    svwh_pkg::sts_t sts;

    logic [svwh_pkg::IDX_W-1:0] out_index;
    logic [SW-1:0]              out_x, out_y, out_z;
    logic                       out_new, out_full;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                svwh_pkg::REG_GMIN_X:  cfg_next.gmin[0]  = pwdata[SW-1:0];
                svwh_pkg::REG_GMIN_Y:  cfg_next.gmin[1]  = pwdata[SW-1:0];
                svwh_pkg::REG_GMIN_Z:  cfg_next.gmin[2]  = pwdata[SW-1:0];
                svwh_pkg::REG_BSIZE_X: cfg_next.bsize[0] = pwdata[ZW-1:0];
                svwh_pkg::REG_BSIZE_Y: cfg_next.bsize[1] = pwdata[ZW-1:0];
                svwh_pkg::REG_BSIZE_Z: cfg_next.bsize[2] = pwdata[ZW-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            svwh_pkg::REG_GMIN_X:  prdata = 32'(cfg_reg.gmin[0]);
            svwh_pkg::REG_GMIN_Y:  prdata = 32'(cfg_reg.gmin[1]);
            svwh_pkg::REG_GMIN_Z:  prdata = 32'(cfg_reg.gmin[2]);
            svwh_pkg::REG_BSIZE_X: prdata = 32'(cfg_reg.bsize[0]);
            svwh_pkg::REG_BSIZE_Y: prdata = 32'(cfg_reg.bsize[1]);
            svwh_pkg::REG_BSIZE_Z: prdata = 32'(cfg_reg.bsize[2]);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gmin  <= '0;
            cfg_reg.bsize <= {ZW'(1), ZW'(1), ZW'(1)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller sequences each transaction; the datapath owns the snapped point,
    // the divider, the bin and entry memories and the result register.
    svwh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_clear (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svwh_datapath #(
        .BINS_PER_AXIS   (BINS_PER_AXIS),
        .MAX_VERTS       (MAX_VERTS),
        .SNAP_STEPS      (SNAP_STEPS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_x      (s_tdata[CWID-1:0]),
        .in_y      (s_tdata[2*CWID-1:CWID]),
        .in_z      (s_tdata[3*CWID-1:2*CWID]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_index (out_index),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_new   (out_new),
        .out_full  (out_full)
    );

    // The result register holds its transaction while m_tready is low.
    assign m_tdata = {2'b00, out_z, out_y, out_x, out_index};
    assign m_tuser = {out_full, out_new};

endmodule
